[rtl/core/sxfc_pkg.sv]
// SysEx frame checker package: shared types, codes and constants.
// No dependencies; every other file in rtl/core uses it by scoped names.
package sxfc_pkg;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 48;

   localparam logic [7:0] SX_START = 8'hF0;
   localparam logic [7:0] SX_END   = 8'hF7;
   localparam logic [6:0] XOR_MASK = 7'h7F;
   localparam int unsigned MIN_LEN = 10;
   localparam int unsigned LEN_W   = 14;
   localparam logic [LEN_W-1:0] LEN_CAP = 14'h3FFF;

   // Frame byte positions that carry meaning
   localparam int unsigned POS_CMD   = 7;
   localparam int unsigned POS_BANK  = 8;
   localparam int unsigned POS_PATCH = 9;
   localparam int unsigned POS_HDR_LAST = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEADER     = 3'd0,
      CSR_DUMP_PATCH = 3'd1,
      CSR_LOAD_PATCH = 3'd2,
      CSR_DUMP_BANK  = 3'd3,
      CSR_LOAD_BANK  = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_BAD_HDR   = 3'd2,
      ST_BAD_END   = 3'd3,
      ST_BAD_CMD   = 3'd4,
      ST_BAD_CSUM  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      KIND_PATCH   = 2'd0,
      KIND_BANK    = 2'd1,
      KIND_NEITHER = 2'd2
   } kind_type;

   typedef struct packed {
      logic [47:0] header_bytes;
      logic [7:0]  cmd_dump_patch;
      logic [7:0]  cmd_load_patch;
      logic [7:0]  cmd_dump_bank;
      logic [7:0]  cmd_load_bank;
   } cfg_type;

   typedef struct packed {
      status_type       status;
      kind_type         kind;
      logic [7:0]       command_code;
      logic [7:0]       bank_number;
      logic [7:0]       patch_number;
      logic [LEN_W-1:0] frame_length;
   } verdict_type;

   // Expected header byte at position 1..6; byte 1 sits in the top bits
   function automatic logic [7:0] hdr_byte(input logic [47:0] hdr, input logic [2:0] pos);
      logic [7:0] sel;
      case (pos)
         3'd1:    sel = hdr[47:40];
         3'd2:    sel = hdr[39:32];
         3'd3:    sel = hdr[31:24];
         3'd4:    sel = hdr[23:16];
         3'd5:    sel = hdr[15:8];
         3'd6:    sel = hdr[7:0];
         default: sel = 8'h00;
      endcase
      return sel;
   endfunction

endpackage

[rtl/core/sxfc_if.sv]
// Valid/ready channel interfaces for the SysEx frame checker.
// Depends on sxfc_pkg for the width of the frame_length field.
interface sxfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sxfc_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [2:0]                status;
   logic [1:0]                kind;
   logic [7:0]                command_code;
   logic [7:0]                bank_number;
   logic [7:0]                patch_number;
   logic [sxfc_pkg::LEN_W-1:0] frame_length;

   modport source (output valid, output status, output kind, output command_code,
                   output bank_number, output patch_number, output frame_length,
                   input ready);
   modport sink   (input valid, input status, input kind, input command_code,
                   input bank_number, input patch_number, input frame_length,
                   output ready);
endinterface

[rtl/core/sysex_frame_checker_top.sv]
// Top level of the SysEx frame checker: config registers, frame tracker, result register.
// Depends on sxfc_pkg, sxfc_if, sxfc_csr and sxfc_track.
//
// Usage:
//   req_bus carries one SysEx byte per beat (data_byte) with last_byte set on the
//   closing byte. rsp_bus carries one verdict per frame: status, kind, command,
//   bank, patch and saturated frame length. Non-closing bytes produce no beat.
//   csr_we/csr_index/csr_wdata write the header bytes and the four command codes;
//   write them only while no frame is in flight.
// Throughput and timing:
//   One byte per cycle while the result slot is free. The verdict appears on rsp_bus
//   in the cycle after the closing byte is accepted. All checks for a byte are a few
//   compares and an XOR between the tracker state and the result register.
// Reset:
//   Synchronous, active high. Clears the frame state, drops any held verdict and
//   restores the register defaults (header 0, codes 0, 1, 2, 3). req_bus.ready
//   is low while reset is high.
// Stall:
//   The result register holds its verdict while rsp_bus.ready is low, and
//   req_bus.ready drops only then; when the verdict is taken a new byte is
//   accepted in the same cycle.
module sysex_frame_checker_top #(
   parameter int unsigned MAX_FRAME = 16383
) (
   input  logic                             clock,
   input  logic                             reset,
   sxfc_req_if.sink                         req_bus,
   sxfc_rsp_if.source                       rsp_bus,
   input  logic                             csr_we,
   input  logic [sxfc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sxfc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   sxfc_pkg::cfg_type     cfg;
   sxfc_pkg::verdict_type verdict;
   sxfc_pkg::verdict_type rsp_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  beat;
   logic                  slot_free;

   // The result slot is free when empty or being drained this cycle
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !reset && slot_free;
   assign beat          = req_bus.valid && req_bus.ready;

   sxfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sxfc_track #(
      .MAX_FRAME (MAX_FRAME)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .beat      (beat),
      .data_byte (req_bus.data_byte),
      .last_byte (req_bus.last_byte),
      .cfg       (cfg),
      .verdict   (verdict)
   );

   // Load a verdict on a closing byte, drop it once taken, otherwise hold
   always_comb begin
      if (beat && req_bus.last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat && req_bus.last_byte) begin
         rsp_ff <= verdict;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_ff.status;
   assign rsp_bus.kind         = rsp_ff.kind;
   assign rsp_bus.command_code = rsp_ff.command_code;
   assign rsp_bus.bank_number  = rsp_ff.bank_number;
   assign rsp_bus.patch_number = rsp_ff.patch_number;
   assign rsp_bus.frame_length = rsp_ff.frame_length;

endmodule

[rtl/core/sxfc_csr.sv]
// Configuration registers of the SysEx frame checker.
// Depends on sxfc_pkg (register indexes, cfg_type).
module sxfc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [sxfc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sxfc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output sxfc_pkg::cfg_type                cfg
);

   sxfc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            sxfc_pkg::CSR_HEADER:     cfg_in.header_bytes   = csr_wdata;
            sxfc_pkg::CSR_DUMP_PATCH: cfg_in.cmd_dump_patch = csr_wdata[7:0];
            sxfc_pkg::CSR_LOAD_PATCH: cfg_in.cmd_load_patch = csr_wdata[7:0];
            sxfc_pkg::CSR_DUMP_BANK:  cfg_in.cmd_dump_bank  = csr_wdata[7:0];
            sxfc_pkg::CSR_LOAD_BANK:  cfg_in.cmd_load_bank  = csr_wdata[7:0];
            default:                  cfg_in = cfg_ff; // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_bytes   <= 48'h0;
         cfg_ff.cmd_dump_patch <= 8'd0;
         cfg_ff.cmd_load_patch <= 8'd1;
         cfg_ff.cmd_dump_bank  <= 8'd2;
         cfg_ff.cmd_load_bank  <= 8'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/sxfc_track.sv]
// Per-frame tracking state and verdict logic of the SysEx frame checker.
// Depends on sxfc_pkg (cfg_type, verdict_type, codes).
module sxfc_track #(
   parameter int unsigned MAX_FRAME = 16383
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  beat,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   input  sxfc_pkg::cfg_type     cfg,
   output sxfc_pkg::verdict_type verdict
);

   localparam int unsigned CW = $clog2(MAX_FRAME + 1);
   localparam int unsigned LW = (CW > sxfc_pkg::LEN_W) ? CW : sxfc_pkg::LEN_W;
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME);

   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    xor_ff, xor_in;
   logic [7:0]    prev_ff, prev_in;
   logic          hdr_ok_ff, hdr_ok_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [7:0]    bank_ff, bank_in;
   logic [7:0]    patch_ff, patch_in;

   logic          hdr_match;
   logic          hdr_ok_now;
   logic [7:0]    cmd_now, bank_now, patch_now;
   logic [CW-1:0] len;
   logic [LW-1:0] len_ext;
   sxfc_pkg::kind_type kind_raw;

   always_comb begin
      if (count_ff == '0) begin
         hdr_match = (data_byte == sxfc_pkg::SX_START);
      end else if (count_ff <= CW'(sxfc_pkg::POS_HDR_LAST)) begin
         hdr_match = (data_byte == sxfc_pkg::hdr_byte(cfg.header_bytes, count_ff[2:0]));
      end else begin
         hdr_match = 1'b1;
      end
      hdr_ok_now = hdr_ok_ff & hdr_match;
      cmd_now    = (count_ff == CW'(sxfc_pkg::POS_CMD))   ? data_byte : cmd_ff;
      bank_now   = (count_ff == CW'(sxfc_pkg::POS_BANK))  ? data_byte : bank_ff;
      patch_now  = (count_ff == CW'(sxfc_pkg::POS_PATCH)) ? data_byte : patch_ff;
      len        = (count_ff < CNT_MAX) ? count_ff + 1'b1 : CNT_MAX;
      len_ext    = LW'(len);
   end

   // Next state: clear on the closing byte, otherwise advance
   always_comb begin
      if (last_byte) begin
         count_in  = '0;
         xor_in    = 8'h00;
         prev_in   = 8'h00;
         hdr_ok_in = 1'b1;
         cmd_in    = 8'h00;
         bank_in   = 8'h00;
         patch_in  = 8'h00;
      end else begin
         count_in  = len;
         xor_in    = (count_ff >= CW'(sxfc_pkg::POS_PATCH)) ? (xor_ff ^ prev_ff) : xor_ff;
         prev_in   = data_byte;
         hdr_ok_in = hdr_ok_now;
         cmd_in    = cmd_now;
         bank_in   = bank_now;
         patch_in  = patch_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         xor_ff    <= 8'h00;
         prev_ff   <= 8'h00;
         hdr_ok_ff <= 1'b1;
         cmd_ff    <= 8'h00;
         bank_ff   <= 8'h00;
         patch_ff  <= 8'h00;
      end else if (beat) begin
         count_ff  <= count_in;
         xor_ff    <= xor_in;
         prev_ff   <= prev_in;
         hdr_ok_ff <= hdr_ok_in;
         cmd_ff    <= cmd_in;
         bank_ff   <= bank_in;
         patch_ff  <= patch_in;
      end
   end

   // Verdict for a closing byte; checks in priority order
   always_comb begin
      if (cmd_now == cfg.cmd_dump_patch || cmd_now == cfg.cmd_load_patch) begin
         kind_raw = sxfc_pkg::KIND_PATCH;
      end else if (cmd_now == cfg.cmd_dump_bank || cmd_now == cfg.cmd_load_bank) begin
         kind_raw = sxfc_pkg::KIND_BANK;
      end else begin
         kind_raw = sxfc_pkg::KIND_NEITHER;
      end

      verdict.kind         = kind_raw;
      verdict.command_code = cmd_now;
      verdict.bank_number  = bank_now;
      verdict.patch_number = (kind_raw == sxfc_pkg::KIND_PATCH) ? patch_now : 8'h00;
      verdict.frame_length = (len_ext > LW'(sxfc_pkg::LEN_CAP)) ?
                             sxfc_pkg::LEN_CAP : len_ext[sxfc_pkg::LEN_W-1:0];

      if (len < CW'(sxfc_pkg::MIN_LEN)) begin
         verdict.status       = sxfc_pkg::ST_SHORT;
         verdict.kind         = sxfc_pkg::KIND_NEITHER;
         verdict.command_code = 8'h00;
         verdict.bank_number  = 8'h00;
         verdict.patch_number = 8'h00;
      end else if (!hdr_ok_now) begin
         verdict.status = sxfc_pkg::ST_BAD_HDR;
      end else if (data_byte != sxfc_pkg::SX_END) begin
         verdict.status = sxfc_pkg::ST_BAD_END;
      end else if (kind_raw == sxfc_pkg::KIND_NEITHER) begin
         verdict.status = sxfc_pkg::ST_BAD_CMD;
      end else if ({1'b0, xor_ff[6:0] & sxfc_pkg::XOR_MASK} != prev_ff) begin
         verdict.status = sxfc_pkg::ST_BAD_CSUM;
      end else begin
         verdict.status = sxfc_pkg::ST_OK;
      end
   end

endmodule

[rtl/core/sxfc_checker.sv]
// Port-level assertions for the SysEx frame checker, bound to the top level.
// Depends on sxfc_pkg (status and kind codes) and sysex_frame_checker_top.
module sxfc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_last,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [2:0]                 rsp_status,
   input logic [1:0]                 rsp_kind,
   input logic [7:0]                 rsp_command,
   input logic [sxfc_pkg::LEN_W-1:0] rsp_length
);

   // Held verdict stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("verdict dropped while stalled");

   // A closing byte always yields a verdict next cycle
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> rsp_valid)
      else $error("closing byte gave no verdict");

   // Input stalls only while a verdict is stuck
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a blocked verdict");

   // A new verdict only follows a closing byte
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last))
      else $error("verdict without closing byte");

   // Short frame verdict carries no command and a length under the minimum
   a_short_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sxfc_pkg::ST_SHORT |->
         rsp_kind == sxfc_pkg::KIND_NEITHER && rsp_command == 8'h00
         && rsp_length < sxfc_pkg::LEN_W'(sxfc_pkg::MIN_LEN))
      else $error("short frame verdict fields wrong");

endmodule

bind sysex_frame_checker_top sxfc_checker u_sxfc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .req_last    (req_bus.last_byte),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_status  (rsp_bus.status),
   .rsp_kind    (rsp_bus.kind),
   .rsp_command (rsp_bus.command_code),
   .rsp_length  (rsp_bus.frame_length)
);
